FILE: src/assert_macros.svh
// Assertion macros for the range exclusion splitter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge while reset is released.
`define RES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset cycles included.
`define RES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RES_ASSERT(lbl, clk, rst_n, prop, msg)
`define RES_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/resplit_pkg.sv
// Shared constants for the range exclusion splitter: default parameters,
// field widths and configuration register indexes. No dependencies.
`default_nettype none

package resplit_pkg;

    // Default parameter values
    localparam int MAX_EXCL_DEF   = 3;
    localparam int ADDR_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 2;
    localparam int NUM_REGS  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL0_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL0_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL1_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL1_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL2_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL2_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_COUNT = 3'd6;

endpackage

`default_nettype wire

FILE: src/range_exclusion_splitter_core.sv
// Range exclusion splitter top level: subtracts configured exclusion ranges
// from one address range. Depends on resplit_pkg and assert_macros.svh.
//
// Takes one range (base, size) on the request input, removes up to
// MAX_EXCLUSIONS configured half-open exclusion ranges from it and returns
// the remaining pieces in ascending address order, one output request each,
// the final one flagged with last_piece; if nothing remains a single request
// with none_left set is returned. Ends are clipped at 2^ADDR_WIDTH. One
// shared adder/clip unit forms the end of the input range and of each
// exclusion, and one compare unit cuts one stored piece per cycle; the
// results then leave one per cycle while the output is ready. The input
// is not ready while an item is in work. Configuration must be written
// only while idle; the user must keep to this, the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module range_exclusion_splitter_core
    import resplit_pkg::*;
#(
    parameter int MAX_EXCLUSIONS = MAX_EXCL_DEF,
    parameter int ADDR_WIDTH     = ADDR_WIDTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration write port
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [DATA_W-1:0]    i_cfg_wdata,
    // input request channel
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire [DATA_W-1:0]    i_range_base,
    input  wire [DATA_W-1:0]    i_range_size,
    // output request channel
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [DATA_W-1:0]   o_piece_base,
    output logic [DATA_W-1:0]   o_piece_size,
    output logic                o_none_left,
    output logic                o_last_piece
);

    localparam int MAXP = MAX_EXCLUSIONS + 1;
    localparam int IW   = $clog2(MAXP);
    localparam int CW   = $clog2(MAXP + 1);
    localparam int SW   = ((ADDR_WIDTH > DATA_W) ? ADDR_WIDTH : DATA_W) + 1;
    localparam int EW   = ADDR_WIDTH + 1;
    localparam logic [SW-1:0] ADDR_LIMIT = {{(SW-1){1'b0}}, 1'b1} << ADDR_WIDTH;
    localparam logic [SW-1:0] ADDR_MASK  = ADDR_LIMIT - {{(SW-1){1'b0}}, 1'b1};
    localparam logic [COUNT_W-1:0] MAXE_V = COUNT_W'(MAX_EXCLUSIONS);
    localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_CUT  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration registers
    logic [DATA_W-1:0]  r_excl_base [NUM_REGS];
    logic [DATA_W-1:0]  r_excl_size [NUM_REGS];
    logic [COUNT_W-1:0] r_excl_count;

    // sequencer and piece lists (two banks, ping-pong)
    logic [1:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_x, n_x;
    logic [IW-1:0]      r_y, n_y;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_ncnt, n_ncnt;
    logic               r_bank, n_bank;
    logic [EW-1:0]      r_xs, r_xe;
    logic [EW-1:0]      r_ps [2][MAXP];
    logic [EW-1:0]      r_pe [2][MAXP];

    // shared end unit signals
    logic [DATA_W-1:0]  u_base, u_size;
    logic [SW-1:0]      u_bext, u_sum;
    logic [EW-1:0]      u_beg, u_end;
    logic               u_live;

    // cut unit signals
    logic [EW-1:0]      cur_s, cur_e;
    logic               cut_miss, cut_lo, cut_hi;
    logic [IW-1:0]      wa0, wa1;
    logic [COUNT_W-1:0] limit;
    logic               last_y, in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign limit   = (r_excl_count > MAXE_V) ? MAXE_V : r_excl_count;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_excl_base[k] <= '0;
                r_excl_size[k] <= '0;
            end
            r_excl_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXCL0_BASE: r_excl_base[0] <= i_cfg_wdata;
                CFG_EXCL0_SIZE: r_excl_size[0] <= i_cfg_wdata;
                CFG_EXCL1_BASE: r_excl_base[1] <= i_cfg_wdata;
                CFG_EXCL1_SIZE: r_excl_size[1] <= i_cfg_wdata;
                CFG_EXCL2_BASE: r_excl_base[2] <= i_cfg_wdata;
                CFG_EXCL2_SIZE: r_excl_size[2] <= i_cfg_wdata;
                CFG_EXCL_COUNT: r_excl_count   <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared end unit: mask base, add size, clip at top of address space
    always_comb begin
        if (r_state == S_IDLE) begin
            u_base = i_range_base;
            u_size = i_range_size;
        end else begin
            case (r_x)
                2'd0:    begin u_base = r_excl_base[0]; u_size = r_excl_size[0]; end
                2'd1:    begin u_base = r_excl_base[1]; u_size = r_excl_size[1]; end
                default: begin u_base = r_excl_base[2]; u_size = r_excl_size[2]; end
            endcase
        end
        u_bext = SW'(u_base) & ADDR_MASK;
        u_sum  = u_bext + SW'(u_size);
        u_beg  = EW'(u_bext);
        u_end  = (u_sum > ADDR_LIMIT) ? EW'(ADDR_LIMIT) : EW'(u_sum);
        u_live = u_end > u_beg;
    end

    // Compare unit: cut the current piece against the loaded exclusion
    always_comb begin
        cur_s    = r_ps[r_bank][r_y];
        cur_e    = r_pe[r_bank][r_y];
        cut_miss = (cur_e <= r_xs) || (cur_s >= r_xe);
        cut_lo   = !cut_miss && (cur_s < r_xs);
        cut_hi   = !cut_miss && (r_xe < cur_e);
        wa0      = r_ncnt[IW-1:0];
        wa1      = cut_lo ? IW'(r_ncnt + ONE_C) : wa0;
        last_y   = (CW'(r_y) + ONE_C) >= r_cnt;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_ncnt  = r_ncnt;
        n_bank  = r_bank;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cnt   = u_live ? ONE_C : '0;
                    n_bank  = 1'b0;
                    n_x     = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_x >= limit) begin
                    n_y     = '0;
                    n_state = S_EMIT;
                end else if (u_live && (r_cnt != '0)) begin
                    n_y     = '0;
                    n_ncnt  = '0;
                    n_state = S_CUT;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_CUT: begin
                n_ncnt = r_ncnt + CW'(cut_miss) + CW'(cut_lo) + CW'(cut_hi);
                if (last_y) begin
                    n_cnt   = n_ncnt;
                    n_bank  = ~r_bank;
                    n_x     = r_x + 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_y = r_y + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    if (o_last_piece) begin
                        n_state = S_IDLE;
                    end else begin
                        n_y = r_y + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_cnt   <= '0;
            r_ncnt  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_cnt   <= n_cnt;
            r_ncnt  <= n_ncnt;
            r_bank  <= n_bank;
        end
    end

    // Load input range, exclusion bounds and cut pieces
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_ps[0][0] <= u_beg;
            r_pe[0][0] <= u_end;
        end
        if (r_state == S_LOAD) begin
            r_xs <= u_beg;
            r_xe <= u_end;
        end
        if (r_state == S_CUT) begin
            if (cut_miss || cut_lo) begin
                r_ps[~r_bank][wa0] <= cur_s;
                r_pe[~r_bank][wa0] <= cut_miss ? cur_e : r_xs;
            end
            if (cut_hi) begin
                r_ps[~r_bank][wa1] <= r_xe;
                r_pe[~r_bank][wa1] <= cur_e;
            end
        end
    end

    // Drive handshakes and result payload
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_none_left  = (r_cnt == '0);
    assign o_last_piece = o_none_left || last_y;
    assign o_piece_base = o_none_left ? '0 : DATA_W'(cur_s);
    assign o_piece_size = o_none_left ? '0 : DATA_W'(cur_e - cur_s);

    // Checks
    `RES_ASSERT(a_busy_excl, i_clk, i_rst_n, o_out_valid |-> !o_in_ready, "input ready while emitting")
    `RES_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAXP), "piece count above limit")
    `RES_ASSERT(a_cut_room, i_clk, i_rst_n, (r_state == S_CUT) |-> (n_ncnt <= CW'(MAXP)), "piece list overflow")
    `RES_ASSERT(a_acc_load, i_clk, i_rst_n, in_acc |=> (r_state == S_LOAD), "accepted item not started")
    `RES_ASSERT(a_last_idle, i_clk, i_rst_n, (out_acc && o_last_piece) |=> o_in_ready, "not idle after last result")

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for range_exclusion_splitter_core: directed and random ranges checked
// against a behavioral model of the exclusion cuts. Depends on resplit_pkg and the RTL.

module tb;
    import resplit_pkg::*;

    // Index past the last register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    // One past the last address, held with one extra bit
    localparam logic [DATA_W:0] ADDR_TOP = {1'b1, {DATA_W{1'b0}}};
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
        logic              none_left;
        logic              last_piece;
    } t_piece;

    // Shadow registers, piece prediction and the queue of pieces still due
    class t_piece_scoreboard;
        logic [DATA_W-1:0]  excl_base [NUM_REGS];
        logic [DATA_W-1:0]  excl_size [NUM_REGS];
        logic [COUNT_W-1:0] excl_count;
        t_piece             expected_pieces [$];
        int                 mismatches;

        function new();
            foreach (excl_base[k]) begin
                excl_base[k] = '0;
                excl_size[k] = '0;
            end
            excl_count = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_EXCL0_BASE: excl_base[0] = data;
                CFG_EXCL0_SIZE: excl_size[0] = data;
                CFG_EXCL1_BASE: excl_base[1] = data;
                CFG_EXCL1_SIZE: excl_size[1] = data;
                CFG_EXCL2_BASE: excl_base[2] = data;
                CFG_EXCL2_SIZE: excl_size[2] = data;
                CFG_EXCL_COUNT: excl_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // End of a half-open range, saturated at the top of the address space
        static function logic [DATA_W:0] clip_end(logic [DATA_W-1:0] base,
                                                  logic [DATA_W-1:0] size);
            logic [DATA_W:0] sum;
            sum = {1'b0, base} + {1'b0, size};
            return (sum > ADDR_TOP) ? ADDR_TOP : sum;
        endfunction

        // Cut the accepted range by each active exclusion and queue what is left
        function void note_range(logic [DATA_W-1:0] base, logic [DATA_W-1:0] size);
            logic [DATA_W:0] lo [$];
            logic [DATA_W:0] hi [$];
            logic [DATA_W:0] cut_lo [$];
            logic [DATA_W:0] cut_hi [$];
            logic [DATA_W:0] xs, xe, top;
            int              active, x;
            t_piece          p;
            top = clip_end(base, size);
            if (top > {1'b0, base}) begin
                lo.push_back({1'b0, base});
                hi.push_back(top);
            end
            active = (excl_count > MAX_EXCL_DEF) ? MAX_EXCL_DEF : excl_count;
            for (x = 0; x < active; x++) begin
                xs = {1'b0, excl_base[x]};
                xe = clip_end(excl_base[x], excl_size[x]);
                // an empty exclusion removes nothing
                if (xe > xs) begin
                    cut_lo.delete();
                    cut_hi.delete();
                    foreach (lo[y]) begin
                        if (hi[y] <= xs || lo[y] >= xe) begin
                            cut_lo.push_back(lo[y]);
                            cut_hi.push_back(hi[y]);
                        end else begin
                            if (lo[y] < xs) begin
                                cut_lo.push_back(lo[y]);
                                cut_hi.push_back(xs);
                            end
                            if (xe < hi[y]) begin
                                cut_lo.push_back(xe);
                                cut_hi.push_back(hi[y]);
                            end
                        end
                    end
                    lo = cut_lo;
                    hi = cut_hi;
                end
            end
            if (lo.size() == 0) begin
                p.base       = '0;
                p.size       = '0;
                p.none_left  = 1'b1;
                p.last_piece = 1'b1;
                expected_pieces.push_back(p);
            end else begin
                foreach (lo[y]) begin
                    p.base       = lo[y][DATA_W-1:0];
                    p.size       = hi[y][DATA_W-1:0] - lo[y][DATA_W-1:0];
                    p.none_left  = 1'b0;
                    p.last_piece = (y == lo.size() - 1);
                    expected_pieces.push_back(p);
                end
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Compare an output request with the oldest piece due
        task check_piece(t_piece got);
            t_piece want;
            if (expected_pieces.size() == 0) begin
                report_mismatch($sformatf("unexpected piece base %h size %h none %b last %b",
                                          got.base, got.size, got.none_left, got.last_piece));
            end else begin
                want = expected_pieces.pop_front();
                if (got.base !== want.base)
                    report_mismatch($sformatf("piece_base %h, want %h", got.base, want.base));
                if (got.size !== want.size)
                    report_mismatch($sformatf("piece_size %h, want %h", got.size, want.size));
                if (got.none_left !== want.none_left)
                    report_mismatch($sformatf("none_left %b, want %b",
                                              got.none_left, want.none_left));
                if (got.last_piece !== want.last_piece)
                    report_mismatch($sformatf("last_piece %b, want %b",
                                              got.last_piece, want.last_piece));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_wdata;
    logic                 req_valid;
    logic [DATA_W-1:0]    req_base;
    logic [DATA_W-1:0]    req_size;
    logic                 out_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [DATA_W-1:0]    o_piece_base;
    logic [DATA_W-1:0]    o_piece_size;
    logic                 o_none_left;
    logic                 o_last_piece;

    bit                idling = 1'b1;
    int                cycle_count = 0;
    t_piece_scoreboard tracker = new();

    range_exclusion_splitter_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (req_valid),
        .o_in_ready   (o_in_ready),
        .i_range_base (req_base),
        .i_range_size (req_size),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_piece_base (o_piece_base),
        .o_piece_size (o_piece_size),
        .o_none_left  (o_none_left),
        .o_last_piece (o_last_piece)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every output request taken
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            tracker.check_piece({o_piece_base, o_piece_size, o_none_left, o_last_piece});
    end

    // Stall the output side in random bursts
    initial begin
        out_ready = 1'b0;
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    function automatic logic [DATA_W-1:0] span_size(int unsigned longest);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, longest);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    // Write all registers, then poke the unused index with noise
    task automatic load_exclusions(input logic [DATA_W-1:0] b0, s0, b1, s1, b2, s2,
                                   input logic [COUNT_W-1:0] cnt);
        write_reg(CFG_EXCL0_BASE, b0);
        write_reg(CFG_EXCL0_SIZE, s0);
        write_reg(CFG_EXCL1_BASE, b1);
        write_reg(CFG_EXCL1_SIZE, s1);
        write_reg(CFG_EXCL2_BASE, b2);
        write_reg(CFG_EXCL2_SIZE, s2);
        write_reg(CFG_EXCL_COUNT, ($urandom & ~32'h3) | cnt);
        write_reg(CFG_NO_REG, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Offer one range, maybe after a gap, and hold it until taken
    task automatic send_range(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] size);
        if (idling && $urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_base  <= base;
        req_size  <= size;
        do @(posedge clk); while (!o_in_ready);
        tracker.note_range(base, size);
    endtask

    // Hold off the input until every piece due has come back
    task automatic drain_pieces();
        req_valid <= 1'b0;
        while (tracker.expected_pieces.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [DATA_W-1:0] win;
        logic [DATA_W-1:0] xb [NUM_REGS];
        logic [DATA_W-1:0] xsz [NUM_REGS];
        int                phase;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req_base  = '0;
        req_size  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No exclusions: empty range, range clipped at the top, plain range
        send_range(32'h0000_0000, 32'h0000_0000);
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_range(32'h0000_1000, 32'h0000_0100);
        drain_pieces();

        // One real exclusion, one empty one, one clipped at the top
        load_exclusions(32'h0000_1000, 32'h0000_0100, 32'h0000_2000, 32'h0000_0000,
                        32'hFFFF_FF00, 32'hFFFF_FFFF, 2'd3);
        send_range(32'h0000_0F00, 32'h0000_0300);   // split around the hole
        send_range(32'h0000_1000, 32'h0000_0100);   // exactly covered
        send_range(32'h0000_0F00, 32'h0000_0100);   // touches the hole from below
        send_range(32'h0000_1100, 32'h0000_0010);   // touches the hole from above
        send_range(32'h0000_1F00, 32'h0000_0200);   // across the empty exclusion
        send_range(32'hFFFF_FE00, 32'h0000_1000);   // runs off the top
        send_range(32'h0000_1080, 32'h0000_0010);   // inside the hole
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        drain_pieces();

        // Three small holes: four pieces from one range
        load_exclusions(32'h0000_0100, 32'h0000_0010, 32'h0000_0200, 32'h0000_0010,
                        32'h0000_0300, 32'h0000_0010, 2'd3);
        send_range(32'h0000_0000, 32'h0000_0400);
        send_range(32'h0000_0180, 32'h0000_0100);
        drain_pieces();

        // Extreme register values
        load_exclusions(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'h0000_0000, 2'd3);
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_range(32'hFFFF_FFFF, 32'h0000_0001);
        send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_range(32'h0000_8000, 32'h0000_0000);
        drain_pieces();

        // Random phases: holes packed in a window, ranges mostly aimed at it
        for (phase = 0; phase < 8; phase++) begin
            idling = (phase < 7);
            case ($urandom_range(0, 3))
                0:       win = 32'h0000_0000;
                1:       win = 32'hFFFF_F000;
                default: win = $urandom;
            endcase
            foreach (xb[k]) begin
                xb[k]  = ($urandom_range(0, 7) == 0) ? $urandom : win + $urandom_range(0, 4095);
                xsz[k] = span_size(1500);
            end
            load_exclusions(xb[0], xsz[0], xb[1], xsz[1], xb[2], xsz[2],
                            COUNT_W'($urandom_range(0, 3)));
            repeat (32) begin
                if ($urandom_range(0, 39) == 0)
                    drain_pieces();
                if ($urandom_range(0, 4) == 0)
                    send_range($urandom, $urandom);
                else
                    send_range(win - 512 + $urandom_range(0, 4607), span_size(5000));
            end
            drain_pieces();
        end

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
